// ----- hw/rtl/sorted_table_linear_interpolator_macros.svh -----
// Assertion macros for the sorted-table linear interpolator.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sti_pkg.sv -----
// Shared constants, types and microcode store for the interpolator.
// Depends on nothing; imported by sorted_table_linear_interpolator.
package sti_pkg;

  // Table size and derived widths.
  localparam int TABLE_POINTS = 256;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int CNT_W        = $clog2(TABLE_POINTS + 1);
  localparam int VAL_W        = 24;
  localparam int DQ_W         = 26;               // quotient bits kept by the divider
  localparam int PROD_W       = 2 * (VAL_W + 1);  // signed product of two differences
  localparam int MAG_W        = PROD_W - 1;       // product magnitude
  localparam int DCNT_W       = $clog2(DQ_W);
  localparam int STEP_W       = 5;

  // Operation codes carried on in_tuser.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_STORED      = 3'd0;
  localparam logic [2:0] ST_FULL        = 3'd1;
  localparam logic [2:0] ST_CLEARED     = 3'd2;
  localparam logic [2:0] ST_EMPTY       = 3'd3;
  localparam logic [2:0] ST_CLAMP_FIRST = 3'd4;
  localparam logic [2:0] ST_CLAMP_LAST  = 3'd5;
  localparam logic [2:0] ST_INTERP      = 3'd6;
  localparam logic [2:0] ST_AVERAGED    = 3'd7;

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses.
  localparam step_t S_IDLE    = 5'd0;
  localparam step_t S_CLR     = 5'd1;
  localparam step_t S_APP     = 5'd2;
  localparam step_t S_QSTART  = 5'd3;
  localparam step_t S_QLAST   = 5'd4;
  localparam step_t S_QENDS   = 5'd5;
  localparam step_t S_PROBE   = 5'd6;
  localparam step_t S_STEP    = 5'd7;
  localparam step_t S_PAIR    = 5'd8;
  localparam step_t S_PAIR1   = 5'd9;
  localparam step_t S_LOAD0   = 5'd10;
  localparam step_t S_LOAD1   = 5'd11;
  localparam step_t S_MUL     = 5'd12;
  localparam step_t S_DIVINIT = 5'd13;
  localparam step_t S_DIV     = 5'd14;
  localparam step_t S_FIN     = 5'd15;
  localparam step_t S_EMIT    = 5'd16;

  // Datapath action of one microinstruction.
  typedef enum logic [3:0] {
    A_NOP, A_LATCH, A_CLEAR, A_APPEND, A_EMPTY, A_FIRST, A_ENDS, A_PROBE,
    A_SEARCH, A_LOAD0, A_LOAD1, A_MUL, A_DIVINIT, A_DIVSTEP, A_FINISH, A_EMIT
  } act_t;

  // Table read address source.
  typedef enum logic [2:0] {
    AS_ZERO, AS_LAST, AS_MID, AS_KM1, AS_K
  } asel_t;

  // Sequencer branch condition.
  typedef enum logic [3:0] {
    C_NEXT, C_JUMP, C_DISPATCH, C_EMPTY, C_CLAMPED, C_SEARCHED, C_DXZERO,
    C_DIVMORE, C_SLOT
  } cond_t;

  typedef struct packed {
    act_t  act;
    asel_t asel;
    cond_t cond;
    step_t target;
  } uword_t;

  // Microprogram store. A read issued at one step is seen on the read
  // register at the following step.
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    unique case (s)
      S_IDLE:    w = '{act: A_LATCH,   asel: AS_ZERO, cond: C_DISPATCH, target: S_IDLE};
      S_CLR:     w = '{act: A_CLEAR,   asel: AS_ZERO, cond: C_JUMP,     target: S_EMIT};
      S_APP:     w = '{act: A_APPEND,  asel: AS_ZERO, cond: C_JUMP,     target: S_EMIT};
      S_QSTART:  w = '{act: A_EMPTY,   asel: AS_ZERO, cond: C_EMPTY,    target: S_EMIT};
      S_QLAST:   w = '{act: A_FIRST,   asel: AS_LAST, cond: C_NEXT,     target: S_IDLE};
      S_QENDS:   w = '{act: A_ENDS,    asel: AS_ZERO, cond: C_CLAMPED,  target: S_EMIT};
      S_PROBE:   w = '{act: A_PROBE,   asel: AS_MID,  cond: C_SEARCHED, target: S_PAIR};
      S_STEP:    w = '{act: A_SEARCH,  asel: AS_ZERO, cond: C_JUMP,     target: S_PROBE};
      S_PAIR:    w = '{act: A_NOP,     asel: AS_ZERO, cond: C_NEXT,     target: S_IDLE};
      S_PAIR1:   w = '{act: A_NOP,     asel: AS_KM1,  cond: C_NEXT,     target: S_IDLE};
      S_LOAD0:   w = '{act: A_LOAD0,   asel: AS_K,    cond: C_NEXT,     target: S_IDLE};
      S_LOAD1:   w = '{act: A_LOAD1,   asel: AS_ZERO, cond: C_NEXT,     target: S_IDLE};
      S_MUL:     w = '{act: A_MUL,     asel: AS_ZERO, cond: C_DXZERO,   target: S_EMIT};
      S_DIVINIT: w = '{act: A_DIVINIT, asel: AS_ZERO, cond: C_NEXT,     target: S_IDLE};
      S_DIV:     w = '{act: A_DIVSTEP, asel: AS_ZERO, cond: C_DIVMORE,  target: S_DIV};
      S_FIN:     w = '{act: A_FINISH,  asel: AS_ZERO, cond: C_JUMP,     target: S_EMIT};
      S_EMIT:    w = '{act: A_EMIT,    asel: AS_ZERO, cond: C_SLOT,     target: S_IDLE};
      default:   w = '{act: A_NOP,     asel: AS_ZERO, cond: C_JUMP,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/sorted_table_linear_interpolator.sv -----
// Piecewise linear interpolator over a sorted (x,y) table, microcoded control.
// Depends on sti_pkg and sorted_table_linear_interpolator_macros.svh.
//
// Usage:
// The input stream carries one command per transfer: in_tuser selects clear,
// append or query, in_tdata holds x and y. Every accepted command yields
// exactly one result transfer with y_result on out_tdata and a status code on
// out_tuser. Values are signed Q3.20.
// A new command is taken only while the sequencer is at its idle step, one
// command at a time. Clear, append and an empty-table query go straight to
// the result; other queries read the first and last points and may clamp,
// else run a binary search (at most 9 probes for 256 points), load the
// bracketing pair and average an equal-x pair or interpolate. Each probe
// reads and uses a point in separate steps, as the point memories have one
// registered read port. The restoring divider gives one quotient bit per cycle.
// The output register holds a finished result while the receiver stalls, and
// the next command is accepted meanwhile; its own result waits at the final
// microstep until the register is free.
// Reset empties the table (the point count goes to zero) and drops any pending
// result; the point memories are not cleared and need no clearing pass.
module sorted_table_linear_interpolator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*sti_pkg::VAL_W-1:0]   in_tdata,   // x_value [23:0], y_value [47:24]
  input  logic [1:0]                    in_tuser,   // operation [1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sti_pkg::VAL_W-1:0]     out_tdata,  // y_result [23:0]
  output logic [2:0]                    out_tuser   // status [2:0]
);
  import sti_pkg::*;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [VAL_W:0]    dif_t;
  typedef logic signed [CNT_W:0]    lh_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DQ_W:0]     qs_t;
  typedef logic signed [DQ_W+1:0]   tot_t;

  localparam val_t VAL_MAX = val_t'({1'b0, {(VAL_W-1){1'b1}}});
  localparam val_t VAL_MIN = val_t'({1'b1, {(VAL_W-1){1'b0}}});

  // Sequencer and control state.
  step_t  step_r, step_nxt;
  uword_t uw;
  logic [CNT_W-1:0] count_r;
  logic   out_tvalid_r;

  // Datapath registers.
  val_t   xq_r, yin_r;
  val_t   x0_r, y0_r;
  logic   desc_r;
  lh_t    lo_r, hi_r;
  logic [IDX_W-1:0] mid_r;
  dif_t   dx_r, dy_r, ex_r, sum_r;
  prod_t  prod_r;
  logic [VAL_W:0]    rem_r, den_r;
  logic [DQ_W-1:0]   nlo_r, q_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic   qneg_r, ovf_r;
  val_t   res_y_r, out_y_r;
  logic [2:0] res_st_r, out_st_r;

  // Point memories.
  val_t   x_mem [TABLE_POINTS];
  val_t   y_mem [TABLE_POINTS];
  val_t   x_rd_r, y_rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic   wr_en;

  // Combinational helpers.
  logic   in_fire, slot_free, emit_fire, full;
  logic   desc_c, clamp_first, clamp_last, go_right;
  lh_t    last_s, mid_s, mid_sum, k_s, km1_s;
  logic [MAG_W-1:0]  pmag;
  logic [VAL_W:0]    dmag;
  logic [VAL_W+1:0]  cand;
  logic   cand_ge;
  dif_t   sum_adj;
  qs_t    qsig;
  tot_t   tot;
  val_t   fin_y;

  assign uw        = ucode_rom(step_r);
  assign in_tready = (step_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign emit_fire = (uw.act == A_EMIT) && slot_free;
  assign full      = (count_r == CNT_W'(TABLE_POINTS));
  assign wr_en     = (uw.act == A_APPEND) && !full;

  // Table end tests, valid while the last point is on the read port.
  assign desc_c      = x0_r > x_rd_r;
  assign clamp_first = desc_c ? (xq_r >= x0_r) : (xq_r <= x0_r);
  assign clamp_last  = desc_c ? (xq_r <= x_rd_r) : (xq_r >= x_rd_r);

  // Search indices.
  assign last_s  = lh_t'({1'b0, count_r}) - lh_t'(1);
  assign mid_sum = lo_r + hi_r;
  assign mid_s   = mid_sum >>> 1;
  assign go_right = desc_r ? (x_rd_r > xq_r) : (x_rd_r < xq_r);

  // Upper point of the bracketing pair, held inside the table.
  always_comb begin
    if (lo_r < lh_t'(1)) begin
      k_s = lh_t'(1);
    end else if (lo_r > last_s) begin
      k_s = last_s;
    end else begin
      k_s = lo_r;
    end
  end
  assign km1_s = k_s - lh_t'(1);

  // Read address selection.
  always_comb begin
    case (uw.asel)
      AS_LAST: rd_addr = last_s[IDX_W-1:0];
      AS_MID:  rd_addr = mid_s[IDX_W-1:0];
      AS_KM1:  rd_addr = km1_s[IDX_W-1:0];
      AS_K:    rd_addr = k_s[IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  // Divider set-up and one restoring step.
  assign pmag    = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
  assign dmag    = dx_r[VAL_W] ? (VAL_W+1)'(-dx_r) : (VAL_W+1)'(dx_r);
  assign cand    = {rem_r, nlo_r[DQ_W-1]};
  assign cand_ge = cand >= {1'b0, den_r};

  // Average of an equal-x pair, rounded toward zero.
  assign sum_adj = sum_r + dif_t'({1'b0, sum_r[VAL_W]});

  // Signed quotient added to y0, then saturated.
  assign qsig = qneg_r ? -qs_t'({1'b0, q_r}) : qs_t'({1'b0, q_r});
  assign tot  = tot_t'(y0_r) + tot_t'(qsig);
  always_comb begin
    if (ovf_r) begin
      fin_y = qneg_r ? VAL_MIN : VAL_MAX;
    end else if (tot > tot_t'(VAL_MAX)) begin
      fin_y = VAL_MAX;
    end else if (tot < tot_t'(VAL_MIN)) begin
      fin_y = VAL_MIN;
    end else begin
      fin_y = tot[VAL_W-1:0];
    end
  end

  // Next microprogram address.
  always_comb begin
    step_nxt = step_r + step_t'(1);
    unique case (uw.cond)
      C_NEXT:     step_nxt = step_r + step_t'(1);
      C_JUMP:     step_nxt = uw.target;
      C_DISPATCH: begin
        if (!in_fire) begin
          step_nxt = step_r;
        end else if (in_tuser == OP_CLEAR) begin
          step_nxt = S_CLR;
        end else if (in_tuser == OP_APPEND) begin
          step_nxt = S_APP;
        end else begin
          step_nxt = S_QSTART;
        end
      end
      C_EMPTY:    if (count_r == '0) step_nxt = uw.target;
      C_CLAMPED:  if (clamp_first || clamp_last) step_nxt = uw.target;
      C_SEARCHED: if (lo_r > hi_r) step_nxt = uw.target;
      C_DXZERO:   if (dx_r == '0) step_nxt = uw.target;
      C_DIVMORE:  if (dcnt_r != '0) step_nxt = uw.target;
      C_SLOT:     step_nxt = slot_free ? uw.target : step_r;
      default:    step_nxt = S_IDLE;
    endcase
  end

  // Point memories with one write and one registered read port each.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[count_r[IDX_W-1:0]] <= xq_r;
      y_mem[count_r[IDX_W-1:0]] <= yin_r;
    end
    x_rd_r <= x_mem[rd_addr];
    y_rd_r <= y_mem[rd_addr];
  end

  // Sequencer, datapath and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (out_tready && !emit_fire) begin
        out_tvalid_r <= 1'b0;
      end
      case (uw.act)
        A_LATCH: begin
          if (in_fire) begin
            xq_r  <= in_tdata[VAL_W-1:0];
            yin_r <= in_tdata[2*VAL_W-1:VAL_W];
          end
        end
        A_CLEAR: begin
          count_r  <= '0;
          res_y_r  <= '0;
          res_st_r <= ST_CLEARED;
        end
        A_APPEND: begin
          res_y_r <= '0;
          if (full) begin
            res_st_r <= ST_FULL;
          end else begin
            count_r  <= count_r + CNT_W'(1);
            res_st_r <= ST_STORED;
          end
        end
        A_EMPTY: begin
          res_y_r  <= '0;
          res_st_r <= ST_EMPTY;
        end
        A_FIRST: begin
          x0_r <= x_rd_r;
          y0_r <= y_rd_r;
        end
        A_ENDS: begin
          desc_r <= desc_c;
          lo_r   <= '0;
          hi_r   <= last_s;
          if (clamp_first) begin
            res_y_r  <= y0_r;
            res_st_r <= ST_CLAMP_FIRST;
          end else if (clamp_last) begin
            res_y_r  <= y_rd_r;
            res_st_r <= ST_CLAMP_LAST;
          end
        end
        A_PROBE: mid_r <= mid_s[IDX_W-1:0];
        A_SEARCH: begin
          if (go_right) begin
            lo_r <= lh_t'({1'b0, CNT_W'(mid_r)}) + lh_t'(1);
          end else begin
            hi_r <= lh_t'({1'b0, CNT_W'(mid_r)}) - lh_t'(1);
          end
        end
        A_LOAD0: begin
          x0_r <= x_rd_r;
          y0_r <= y_rd_r;
        end
        A_LOAD1: begin
          dx_r  <= dif_t'(x_rd_r) - dif_t'(x0_r);
          dy_r  <= dif_t'(y_rd_r) - dif_t'(y0_r);
          ex_r  <= dif_t'(xq_r) - dif_t'(x0_r);
          sum_r <= dif_t'(y0_r) + dif_t'(y_rd_r);
        end
        A_MUL: begin
          prod_r   <= ex_r * dy_r;
          res_y_r  <= sum_adj[VAL_W:1];
          res_st_r <= ST_AVERAGED;
        end
        A_DIVINIT: begin
          den_r  <= dmag;
          rem_r  <= (VAL_W+1)'(pmag >> DQ_W);
          nlo_r  <= pmag[DQ_W-1:0];
          q_r    <= '0;
          dcnt_r <= DCNT_W'(DQ_W - 1);
          qneg_r <= prod_r[PROD_W-1] ^ dx_r[VAL_W];
          ovf_r  <= (MAG_W+3)'(pmag) >= {1'b0, dmag, {DQ_W{1'b0}}};
        end
        A_DIVSTEP: begin
          if (cand_ge) begin
            rem_r <= (VAL_W+1)'(cand - {1'b0, den_r});
          end else begin
            rem_r <= cand[VAL_W:0];
          end
          nlo_r  <= {nlo_r[DQ_W-2:0], 1'b0};
          q_r    <= {q_r[DQ_W-2:0], cand_ge};
          dcnt_r <= dcnt_r - DCNT_W'(1);
        end
        A_FINISH: begin
          res_y_r  <= fin_y;
          res_st_r <= ST_INTERP;
        end
        A_EMIT: begin
          if (slot_free) begin
            out_tvalid_r <= 1'b1;
            out_y_r      <= res_y_r;
            out_st_r     <= res_st_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_y_r;
  assign out_tuser  = out_st_r;

  // Checks on the sequencer and the table bookkeeping.
  `include "sorted_table_linear_interpolator_macros.svh"

  `STI_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_POINTS), "point count overflow")
  `STI_ASSERT_NOW(a_pair_inside, step_r == S_PAIR, (k_s >= lh_t'(1)) && (k_s <= last_s), "pair index outside table")
  `STI_ASSERT_NEXT(a_dispatch, in_fire, step_r != S_IDLE, "accepted command not dispatched")
  `STI_ASSERT_NOW(a_emit_free, emit_fire, !out_tvalid_r || out_tready, "result overwrote pending transfer")

endmodule
